/* rtl/can_encoder_count_reporter_core_assert.svh */
// ---------------------------------------------------------------------------
// Assertion macros
// Shared property shorthands for the encoder reporter checkers.
// ---------------------------------------------------------------------------
`ifndef CAN_ENCODER_COUNT_REPORTER_CORE_ASSERT_SVH
`define CAN_ENCODER_COUNT_REPORTER_CORE_ASSERT_SVH

// antecedent in this cycle implies consequent in the next, quiet during reset
`define CERC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("cerc assertion failed");

// same cycle implication, quiet during reset
`define CERC_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("cerc assertion failed");

// next cycle implication that also holds across reset
`define CERC_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("cerc assertion failed");

`endif

/* rtl/cerc_pkg.sv */
// ---------------------------------------------------------------------------
// cerc_pkg
// Types and constants shared by the encoder count reporter modules.
// ---------------------------------------------------------------------------
package cerc_pkg;

   // report mode selected by the period command
   typedef enum logic [1:0] {
      MODE_NONE     = 2'd0,
      MODE_PERIODIC = 2'd1,
      MODE_REQUEST  = 2'd2
   } mode_type;

   localparam logic [10:0] TX_ID_RESET    = 11'h440;
   localparam logic [10:0] FILTER_OFFSET  = 11'h040;
   localparam logic [11:0] REQUEST_OFFSET = 12'h001;
   localparam logic [15:0] PERIOD_REQUEST = 16'hFFFF;
   localparam logic [15:0] ELAPSED_MAX    = 16'hFFFF;

   // frame lengths, and command codes carried in the first data byte
   localparam logic [3:0] LEN_ARM    = 4'd1;
   localparam logic [3:0] LEN_ASK    = 4'd2;
   localparam logic [3:0] LEN_PERIOD = 4'd3;
   localparam logic [7:0] CMD_ARM    = 8'd0;
   localparam logic [7:0] CMD_PERIOD = 8'd1;

   // result queue geometry
   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);
   localparam int unsigned QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

   // one result beat
   typedef struct packed {
      logic signed [31:0] count_delta;
      logic               reply_kind;
      logic               is_last;
   } rslt_type;

   // queue write strobes for one item
   typedef struct packed {
      logic wr0;
      logic wr1;
   } push_type;

endpackage

/* rtl/cerc_resp_queue.sv */
// ---------------------------------------------------------------------------
// cerc_resp_queue
// Small result queue: up to two beats written per cycle, one read.
// ---------------------------------------------------------------------------
module cerc_resp_queue (
   input  logic                                 clock,
   input  logic                                 reset,
   input  cerc_pkg::push_type                   push,
   input  cerc_pkg::rslt_type                   rslt0,
   input  cerc_pkg::rslt_type                   rslt1,
   input  logic                                 pop,
   output cerc_pkg::rslt_type                   head,
   output logic [cerc_pkg::QUEUE_CW-1:0]        level
);
   import cerc_pkg::*;

   rslt_type              mem [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CW-1:0]   cnt_ff, cnt_in;
   logic [QUEUE_AW-1:0]   wr_ptr_nx;

   // pointer and level update
   always_comb begin
      wr_ptr_nx = wr_ptr_ff + QUEUE_AW'(1);
      wr_ptr_in = wr_ptr_ff + QUEUE_AW'(push.wr0) + QUEUE_AW'(push.wr1);
      rd_ptr_in = rd_ptr_ff + QUEUE_AW'(pop);
      cnt_in    = cnt_ff + QUEUE_CW'(push.wr0) + QUEUE_CW'(push.wr1) - QUEUE_CW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // storage, no reset
   always_ff @(posedge clock) begin
      if (push.wr0) begin
         mem[wr_ptr_ff] <= rslt0;
      end
      if (push.wr1) begin
         mem[wr_ptr_nx] <= rslt1;
      end
   end

   assign head  = mem[rd_ptr_ff];
   assign level = cnt_ff;

endmodule

/* rtl/can_encoder_count_reporter_core.sv */
// ---------------------------------------------------------------------------
// can_encoder_count_reporter_core
// Filters CAN command frames, tracks the encoder reference and report
// period, and emits count reports on millisecond ticks.
// ---------------------------------------------------------------------------
//  Channel | Direction | Handshake           | Beat
//  req_    | in        | req_valid/req_stall | frame or tick, live count
//  rsp_    | out       | rsp_valid/rsp_stall | count delta, kind, last flag
//  csr_    | in        | csr_valid/csr_ready | tx_id write
//
// One item is taken per cycle while req_stall is low; its state update and
// results settle in the same cycle and land in a four-entry result queue.
// req_stall rises while three or more results wait, so a tick that makes two
// results always finds room; with rsp_stall low the queue drains one a cycle.
// Synchronous reset clears the control state and empties the queue; tx_id
// returns to 0x440 and the period to 0xFFFF. csr_ready is always high.
// ---------------------------------------------------------------------------
module can_encoder_count_reporter_core (
   input  logic               clock,
   input  logic               reset,
   // request channel
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_kind,
   input  logic [10:0]        req_frame_id,
   input  logic [3:0]         req_frame_length,
   input  logic [7:0]         req_byte0,
   input  logic [7:0]         req_byte1,
   input  logic [7:0]         req_byte2,
   input  logic signed [31:0] req_encoder_count,
   // result channel
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_count_delta,
   output logic               rsp_reply_kind,
   output logic               rsp_is_last,
   // configuration
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [10:0]        csr_tx_id
);
   import cerc_pkg::*;

   logic [10:0]   tx_id_ff, tx_id_in;
   logic          armed_ff, armed_in;
   mode_type      mode_ff, mode_in;
   logic [31:0]   ref_ff, ref_in;
   logic [15:0]   period_ff, period_in;
   logic [15:0]   elapsed_ff, elapsed_in;
   logic          pending_ff, pending_in;

   logic          accept;
   logic          is_frame, is_tick;
   logic          id_match;
   logic [11:0]   req_id_ext;
   logic          do_arm, do_period, do_ask;
   logic [15:0]   period_cmd;
   logic [15:0]   elapsed_inc;
   logic          fire_periodic, fire_request;
   logic [31:0]   delta;
   push_type      push;
   rslt_type      rslt0, rslt1, head;
   logic [QUEUE_CW-1:0] level;

   assign accept    = req_valid && !req_stall;
   assign is_frame  = accept && !req_kind;
   assign is_tick   = accept && req_kind;
   assign csr_ready = 1'b1;

   // receive filter
   always_comb begin
      req_id_ext = {1'b0, req_frame_id};
      unique case (mode_ff)
         MODE_REQUEST: id_match = (req_id_ext == ({1'b0, tx_id_ff} + REQUEST_OFFSET));
         default:      id_match = (tx_id_ff >= FILTER_OFFSET) &&
                                  (req_frame_id == (tx_id_ff - FILTER_OFFSET));
      endcase
   end

   // command decode
   always_comb begin
      period_cmd = {req_byte2, req_byte1};
      do_arm     = is_frame && id_match && (req_frame_length == LEN_ARM) &&
                   (req_byte0 == CMD_ARM);
      do_period  = is_frame && id_match && (req_frame_length == LEN_PERIOD) &&
                   (req_byte0 == CMD_PERIOD) && armed_ff;
      do_ask     = is_frame && id_match && (req_frame_length == LEN_ASK);
   end

   // tick timing and report decisions
   always_comb begin
      elapsed_inc   = (elapsed_ff == ELAPSED_MAX) ? elapsed_ff : elapsed_ff + 16'd1;
      fire_periodic = is_tick && armed_ff && (mode_ff == MODE_PERIODIC) &&
                      (elapsed_inc >= period_ff);
      fire_request  = is_tick && armed_ff && pending_ff;
      delta         = req_encoder_count - ref_ff;
   end

   // next state of the report mode
   always_comb begin
      mode_in = mode_ff;
      if (do_period) begin
         mode_in = (period_cmd == PERIOD_REQUEST) ? MODE_REQUEST : MODE_PERIODIC;
      end
   end

   // next values of the remaining state
   always_comb begin
      tx_id_in   = (csr_valid && csr_ready) ? csr_tx_id : tx_id_ff;
      armed_in   = armed_ff || do_arm;
      ref_in     = do_arm ? req_encoder_count : ref_ff;
      period_in  = do_period ? period_cmd : period_ff;
      pending_in = pending_ff;
      if (do_ask) begin
         pending_in = 1'b1;
      end else if (fire_request) begin
         pending_in = 1'b0;
      end
      elapsed_in = elapsed_ff;
      if (is_tick) begin
         elapsed_in = fire_periodic ? 16'd0 : elapsed_inc;
      end
   end

   // result beats for this item
   always_comb begin
      push.wr0          = fire_periodic || fire_request;
      push.wr1          = fire_periodic && fire_request;
      rslt0.count_delta = $signed(delta);
      rslt0.reply_kind  = !fire_periodic;
      rslt0.is_last     = !(fire_periodic && fire_request);
      rslt1.count_delta = $signed(delta);
      rslt1.reply_kind  = 1'b1;
      rslt1.is_last     = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tx_id_ff   <= TX_ID_RESET;
         armed_ff   <= 1'b0;
         mode_ff    <= MODE_NONE;
         ref_ff     <= '0;
         period_ff  <= PERIOD_REQUEST;
         elapsed_ff <= '0;
         pending_ff <= 1'b0;
      end else begin
         tx_id_ff   <= tx_id_in;
         armed_ff   <= armed_in;
         mode_ff    <= mode_in;
         ref_ff     <= ref_in;
         period_ff  <= period_in;
         elapsed_ff <= elapsed_in;
         pending_ff <= pending_in;
      end
   end

   // result queue
   cerc_resp_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .rslt0 (rslt0),
      .rslt1 (rslt1),
      .pop   (rsp_valid && !rsp_stall),
      .head  (head),
      .level (level)
   );

   assign req_stall       = (level > QUEUE_CW'(QUEUE_DEPTH - 2));
   assign rsp_valid       = (level != '0);
   assign rsp_count_delta = head.count_delta;
   assign rsp_reply_kind  = head.reply_kind;
   assign rsp_is_last     = head.is_last;

endmodule

/* rtl/cerc_checker.sv */
// ---------------------------------------------------------------------------
// cerc_checker
// Port level checks for the encoder count reporter, bound to the top level.
// ---------------------------------------------------------------------------
`include "can_encoder_count_reporter_core_assert.svh"

module cerc_checker (
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic signed [31:0] rsp_count_delta,
   input logic               rsp_reply_kind,
   input logic               rsp_is_last,
   input logic               csr_valid,
   input logic               csr_ready
);

   // result channel holds a stalled beat
   `CERC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid)
   `CERC_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && rsp_stall, $stable(rsp_count_delta) && $stable(rsp_reply_kind) && $stable(rsp_is_last))

   // reset empties the result queue
   `CERC_ASSERT_NEXT_ALWAYS(a_reset_empty, clock, reset, !rsp_valid)

   // a first beat of a pair is periodic and its requested partner follows
   `CERC_ASSERT_NEXT(a_pair_follows, clock, reset, rsp_valid && !rsp_stall && !rsp_is_last, rsp_valid && rsp_reply_kind && $past(!rsp_reply_kind))

   // configuration writes are never refused
   `CERC_ASSERT_NOW(a_csr_ready, clock, reset, csr_valid, csr_ready)

endmodule

bind can_encoder_count_reporter_core cerc_checker u_cerc_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_count_delta (rsp_count_delta),
   .rsp_reply_kind  (rsp_reply_kind),
   .rsp_is_last     (rsp_is_last),
   .csr_valid       (csr_valid),
   .csr_ready       (csr_ready)
);
